>>> src/brat_pkg.sv
// shared types, codes and constants of the burst receive ack tracker
`default_nettype none

package brat_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int BITMAP_W   = 16;
  localparam int NOW_W      = 48;
  localparam int AIR_W      = 20;
  localparam int GROUP_W    = 4;
  localparam int FRAME_W    = 4;
  // 5 * airtime * (max_group_size + 1)
  localparam int SPAN_W     = AIR_W + 3 + GROUP_W + 1;
  localparam int REM_W      = FRAME_W + 1;
  localparam int PADDR_W    = 3;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PACKET  = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    NS_AWAIT = 2'd0,
    NS_ACK   = 2'd1,
    NS_CRASH = 2'd2
  } next_state_t;

  // register index within the configuration map
  typedef enum logic {
    REG_AIRTIME = 1'b0,
    REG_GROUP   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [NOW_W-1:0]   now_us;
    logic [FRAME_W-1:0] frame_index;
    logic [FRAME_W-1:0] burst_last_index;
    logic               parity_bit;
    logic               first_burst_flag;
  } in_t;

  typedef struct packed {
    next_state_t         next_state;
    logic                deadline_valid;
    logic [NOW_W-1:0]    deadline_us;
    logic                new_burst;
    logic                flush_send;
    logic                forward_packet;
    logic [BITMAP_W-1:0] ack_bitmap;
  } out_t;

  // configuration as seen by the tracking logic
  typedef struct packed {
    logic [AIR_W-1:0]  airtime;
    logic [SPAN_W-1:0] start_span;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/brat_cfg_regs.sv
// configuration register file with precomputed start window length
`default_nettype none

module brat_cfg_regs
  import brat_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready,
  output cfg_t                    cfg
);

  logic [AIR_W-1:0]   airtime_r;
  logic [GROUP_W-1:0] group_r;
  logic [SPAN_W-1:0]  span_r;
  logic [SPAN_W-1:0]  span_nxt;
  logic               wr_en;
  reg_idx_t           idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      airtime_r <= '0;
      group_r   <= GROUP_W'(15);
    end else if (wr_en) begin
      unique case (idx)
        REG_AIRTIME: airtime_r <= cfg_pwdata[AIR_W-1:0];
        REG_GROUP:   group_r   <= cfg_pwdata[GROUP_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AIRTIME: cfg_prdata = 32'(airtime_r);
      REG_GROUP:   cfg_prdata = 32'(group_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // times five by shift and add, then one small multiply, registered
  always_comb begin
    span_nxt = SPAN_W'(({3'b000, airtime_r} << 2) + {3'b000, airtime_r})
             * SPAN_W'({1'b0, group_r} + (GROUP_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  assign cfg.airtime    = airtime_r;
  assign cfg.start_span = span_r;

endmodule

`default_nettype wire

>>> src/brat_core.sv
// burst tracking state and per-transaction result logic
`default_nettype none

module brat_core
  import brat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic upd_en,
  input  in_t       item,
  input  cfg_t      cfg,
  output out_t      res
);

  logic                ctx_r, ctx_nxt;
  logic                restart_r, restart_nxt;
  logic                par_r, par_nxt;
  logic [FRAME_W-1:0]  last_r, last_nxt;
  logic                prev_vld_r, prev_vld_nxt;
  logic [FRAME_W-1:0]  prev_r, prev_nxt;
  logic [BITMAP_W-1:0] bitmap_r, bitmap_nxt;
  logic                recv_r, recv_nxt;

  logic                newb;
  logic                flush;
  logic [REM_W-1:0]    end_cnt;
  logic [REM_W-1:0]    rem;
  logic [AIR_W+REM_W-1:0] air_prod;
  logic [BITMAP_W-1:0] frame_bit;

  always_comb begin
    newb  = 1'b0;
    flush = 1'b0;
    if (!ctx_r) begin
      newb = 1'b1;
    end else if (item.first_burst_flag && !restart_r) begin
      newb = 1'b1;
    end else if (par_r != item.parity_bit) begin
      newb  = 1'b1;
      flush = 1'b1;
    end else if (last_r != item.burst_last_index ||
                 (prev_vld_r && item.frame_index < prev_r)) begin
      newb = 1'b1;
    end
  end

  always_comb begin
    frame_bit = '0;
    if (int'(item.frame_index) < MAX_FRAMES) begin
      frame_bit = BITMAP_W'(1) << item.frame_index;
    end
  end

  // frames from this one to the burst end, floored at zero
  always_comb begin
    end_cnt  = {1'b0, last_nxt} + REM_W'(1);
    rem      = (end_cnt >= {1'b0, item.frame_index})
             ? end_cnt - {1'b0, item.frame_index} : '0;
    air_prod = cfg.airtime * (AIR_W+REM_W)'(rem);
  end

  always_comb begin
    ctx_nxt      = ctx_r;
    restart_nxt  = restart_r;
    par_nxt      = par_r;
    last_nxt     = last_r;
    prev_vld_nxt = prev_vld_r;
    prev_nxt     = prev_r;
    bitmap_nxt   = bitmap_r;
    recv_nxt     = recv_r;

    res                = '0;
    res.next_state     = NS_AWAIT;

    case (item.cmd)
      CMD_START: begin
        recv_nxt           = 1'b0;
        res.deadline_valid = 1'b1;
        res.deadline_us    = item.now_us + NOW_W'(cfg.start_span);
      end
      CMD_PACKET: begin
        recv_nxt     = 1'b1;
        ctx_nxt      = 1'b1;
        prev_vld_nxt = 1'b1;
        prev_nxt     = item.frame_index;
        if (newb) begin
          last_nxt    = item.burst_last_index;
          par_nxt     = item.parity_bit;
          restart_nxt = item.first_burst_flag;
          bitmap_nxt  = frame_bit;
        end else begin
          bitmap_nxt  = bitmap_r | frame_bit;
        end
        res.new_burst      = newb;
        res.flush_send     = flush;
        res.forward_packet = 1'b1;
        if (last_nxt == item.frame_index) begin
          res.next_state = NS_ACK;
        end else begin
          res.deadline_valid = 1'b1;
          res.deadline_us    = item.now_us + NOW_W'(air_prod);
        end
      end
      CMD_TIMEOUT: begin
        res.next_state = recv_r ? NS_ACK : NS_CRASH;
      end
      default: ;
    endcase
    res.ack_bitmap = bitmap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r      <= 1'b0;
      restart_r  <= 1'b0;
      par_r      <= 1'b0;
      last_r     <= '0;
      prev_vld_r <= 1'b0;
      prev_r     <= '0;
      bitmap_r   <= '0;
      recv_r     <= 1'b0;
    end else if (upd_en) begin
      ctx_r      <= ctx_nxt;
      restart_r  <= restart_nxt;
      par_r      <= par_nxt;
      last_r     <= last_nxt;
      prev_vld_r <= prev_vld_nxt;
      prev_r     <= prev_nxt;
      bitmap_r   <= bitmap_nxt;
      recv_r     <= recv_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/burst_receive_ack_tracker_top.sv
// an input transaction passes the input register, then the result register, before out_valid
// throughput: one transaction per cycle unless the output stalls, set by the state update
// between the input register and the result register
// reset (synchronous, rst_n low): pipeline empty, tracking state cleared,
// airtime 0 and max group size 15
`default_nettype none

module burst_receive_ack_tracker_top
  import brat_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  in_t                     in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic      [31:0]        cfg_prdata,
  output logic                    cfg_pready
);

  cfg_t cfg;
  in_t  item_r;
  logic item_vld_r;
  out_t res;
  out_t res_r;
  logic res_vld_r;
  logic adv;

  brat_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // the result register takes a new value when empty or being drained
  assign adv      = !res_vld_r || out_ready;
  assign in_ready = !item_vld_r || adv;

  brat_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (item_vld_r && adv),
    .item   (item_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (adv) begin
        res_vld_r <= item_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (adv && item_vld_r) begin
      res_r <= res;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

endmodule

`default_nettype wire

>>> src/brat_checker.sv
// port-level checks of the tracker, bound to the top level
`default_nettype none

module brat_checker
  import brat_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // flush only comes with a new burst of a forwarded packet
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.flush_send |-> out_data.new_burst && out_data.forward_packet)
    else $error("flush without new burst");

  a_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.deadline_valid |-> out_data.deadline_us == '0)
    else $error("deadline value without deadline_valid");

  // a crash answer carries no deadline and no packet
  a_crash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.next_state == NS_CRASH |->
      !out_data.deadline_valid && !out_data.forward_packet)
    else $error("crash result with packet fields");

endmodule

bind burst_receive_ack_tracker_top brat_checker u_brat_checker (.*);

`default_nettype wire

>>> tb/sv/burst_receive_ack_tracker_top_tb.sv
// self-checking testbench of the burst receive ack tracker with a built-in predictor
module burst_receive_ack_tracker_top_tb;
  import brat_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          IDLE_PCT     = 32;
  localparam int          PHASE_ITEMS  = 200;
  localparam logic [47:0] SPAN_FACTOR  = 48'd5;
  localparam logic [19:0] AIRTIME_MAX  = 20'hFFFFF;
  localparam logic [3:0]  GROUP_MAX    = 4'hF;
  localparam logic [47:0] NOW_MAX      = 48'hFFFF_FFFF_FFFF;
  // command code that the block has to ignore
  localparam cmd_t        CMD_UNUSED   = cmd_t'(2'd3);

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  in_t                in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  out_t               out_data;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]        cfg_pwdata  = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  burst_receive_ack_tracker_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // tracker state as predicted
  logic             trk_started       = 1'b0;
  logic             trk_restart_seen  = 1'b0;
  logic             trk_parity        = 1'b0;
  logic [3:0]       trk_last_idx      = '0;
  logic             trk_prev_valid    = 1'b0;
  logic [3:0]       trk_prev_frame    = '0;
  logic [15:0]      trk_bitmap        = '0;
  logic             trk_received      = 1'b0;
  logic [AIR_W-1:0] cfg_airtime       = '0;
  logic [3:0]       cfg_group         = GROUP_MAX;

  out_t        awaited_results[$];
  int          error_count  = 0;
  int          cycle_count  = 0;
  int          items_sent   = 0;
  int          sink_hold    = 0;
  bit          sender_calm  = 1'b0;
  bit          sink_calm    = 1'b0;
  logic [47:0] wall_us      = 48'd1000;
  logic        link_parity  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result sink: random stalls, calm stretches and a counted hold-off
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic out_t ack_tracker_result(in_t item);
    out_t       res;
    logic [4:0] remaining;
    logic       fresh;
    res       = '0;
    remaining = '0;
    fresh     = 1'b0;
    case (item.cmd)
      CMD_START: begin
        trk_received       = 1'b0;
        res.deadline_valid = 1'b1;
        res.deadline_us    = item.now_us + SPAN_FACTOR * 48'(cfg_airtime)
                             * (48'(cfg_group) + 48'd1);
      end
      CMD_PACKET: begin
        trk_received = 1'b1;
        if (!trk_started) begin
          fresh = 1'b1;
        end else if (item.first_burst_flag && !trk_restart_seen) begin
          fresh = 1'b1;
        end else if (item.parity_bit != trk_parity) begin
          fresh         = 1'b1;
          res.flush_send = 1'b1;
        end else if (item.burst_last_index != trk_last_idx ||
                     (trk_prev_valid && item.frame_index < trk_prev_frame)) begin
          fresh = 1'b1;
        end
        if (fresh) begin
          trk_last_idx     = item.burst_last_index;
          trk_parity       = item.parity_bit;
          trk_bitmap       = '0;
          trk_restart_seen = item.first_burst_flag;
        end
        trk_started    = 1'b1;
        trk_prev_valid = 1'b1;
        trk_prev_frame = item.frame_index;
        if (int'(item.frame_index) < MAX_FRAMES)
          trk_bitmap[item.frame_index] = 1'b1;
        res.new_burst      = fresh;
        res.forward_packet = 1'b1;
        if (trk_last_idx == item.frame_index) begin
          res.next_state = NS_ACK;
        end else begin
          // frames past the burst end leave the deadline at now
          if ({1'b0, trk_last_idx} + 5'd1 >= {1'b0, item.frame_index})
            remaining = {1'b0, trk_last_idx} + 5'd1 - {1'b0, item.frame_index};
          res.deadline_valid = 1'b1;
          res.deadline_us    = item.now_us + 48'(cfg_airtime) * 48'(remaining);
        end
      end
      CMD_TIMEOUT: begin
        res.next_state = trk_received ? NS_ACK : NS_CRASH;
      end
      default: begin
      end
    endcase
    res.ack_bitmap = trk_bitmap;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // compare each result with the oldest prediction, then predict accepted transactions
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, out_data);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("next_state", 64'(want.next_state), 64'(out_data.next_state));
        check_field("deadline_valid", 64'(want.deadline_valid),
                    64'(out_data.deadline_valid));
        check_field("deadline_us", 64'(want.deadline_us), 64'(out_data.deadline_us));
        check_field("new_burst", 64'(want.new_burst), 64'(out_data.new_burst));
        check_field("flush_send", 64'(want.flush_send), 64'(out_data.flush_send));
        check_field("forward_packet", 64'(want.forward_packet),
                    64'(out_data.forward_packet));
        check_field("ack_bitmap", 64'(want.ack_bitmap), 64'(out_data.ack_bitmap));
      end
    end
    if (rst_n && in_valid && in_ready)
      awaited_results.push_back(ack_tracker_result(in_data));
  end

  task automatic send_item(in_t item);
    if (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop sending and wait until every pending result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    logic [31:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_AIRTIME: cfg_airtime = value[AIR_W-1:0];
      REG_GROUP:   cfg_group   = value[3:0];
      default: begin
      end
    endcase
    // read back what was written
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field(idx == REG_AIRTIME ? "airtime readback" : "group readback",
                idx == REG_AIRTIME ? 64'(cfg_airtime) : 64'(cfg_group), 64'(readback));
  endtask

  function automatic in_t item_at(cmd_t c, logic [47:0] now, logic [3:0] frame,
                                  logic [3:0] last_idx, logic par, logic first);
    in_t item;
    item.cmd              = c;
    item.now_us           = now;
    item.frame_index      = frame;
    item.burst_last_index = last_idx;
    item.parity_bit       = par;
    item.first_burst_flag = first;
    return item;
  endfunction

  function automatic logic [47:0] advance_wall();
    wall_us = wall_us + 48'($urandom_range(1, 3000));
    return wall_us;
  endfunction

  function automatic in_t noise_item();
    return item_at(cmd_t'($urandom_range(3)), 48'({$urandom, $urandom}),
                   4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // one receive window: start, a burst with drops and strays, maybe a timeout
  task automatic run_window();
    int         last_idx;
    logic [3:0] frame;
    last_idx = $urandom_range(15);
    send_item(item_at(CMD_START, advance_wall(), 4'($urandom), 4'($urandom),
                      1'($urandom), 1'($urandom)));
    for (int f = 0; f <= last_idx; f++) begin
      frame = 4'(f);
      if ($urandom_range(99) < 6) frame = 4'($urandom);
      if ($urandom_range(99) >= 12)
        send_item(item_at(CMD_PACKET, advance_wall(), frame, 4'(last_idx), link_parity,
                          $urandom_range(99) < 8));
      if ($urandom_range(99) < 5)
        send_item(item_at(CMD_PACKET, advance_wall(), frame, 4'(last_idx), link_parity,
                          1'b0));
    end
    if ($urandom_range(99) < 30)
      send_item(item_at(CMD_TIMEOUT, advance_wall(), 4'($urandom), 4'($urandom),
                        1'($urandom), 1'($urandom)));
    if ($urandom_range(99) < 75) link_parity = ~link_parity;
  endtask

  task automatic test_idle_commands();
    send_item(item_at(CMD_TIMEOUT, 48'd0, 4'd0, 4'd0, 1'b0, 1'b0));
    send_item(item_at(CMD_UNUSED, NOW_MAX, 4'hF, 4'hF, 1'b1, 1'b1));
    send_item(item_at(CMD_START, NOW_MAX, 4'd0, 4'd0, 1'b0, 1'b0));
    wait_idle();
    cfg_write(REG_AIRTIME, 32'(AIRTIME_MAX));
    cfg_write(REG_GROUP, 32'(GROUP_MAX));
    // largest start span, wrapping past the top of the time range
    send_item(item_at(CMD_START, NOW_MAX - 48'd5, 4'd0, 4'd0, 1'b0, 1'b0));
    wait_idle();
    cfg_write(REG_GROUP, 32'd0);
    send_item(item_at(CMD_START, 48'd7, 4'd0, 4'd0, 1'b0, 1'b0));
    wait_idle();
  endtask

  task automatic test_burst_rules();
    cfg_write(REG_AIRTIME, 32'd1000);
    cfg_write(REG_GROUP, 32'd3);
    send_item(item_at(CMD_START, 48'd100, 4'd0, 4'd0, 1'b0, 1'b0));
    // no context yet
    send_item(item_at(CMD_PACKET, 48'd200, 4'd0, 4'd3, 1'b0, 1'b0));
    send_item(item_at(CMD_PACKET, 48'd300, 4'd1, 4'd3, 1'b0, 1'b0));
    // restart flag not yet seen, then seen
    send_item(item_at(CMD_PACKET, 48'd400, 4'd1, 4'd3, 1'b0, 1'b1));
    send_item(item_at(CMD_PACKET, 48'd500, 4'd2, 4'd3, 1'b0, 1'b1));
    // parity toggle asks for a flush
    send_item(item_at(CMD_PACKET, 48'd600, 4'd0, 4'd3, 1'b1, 1'b0));
    // burst size change
    send_item(item_at(CMD_PACKET, 48'd700, 4'd2, 4'd5, 1'b1, 1'b0));
    // frame going backward
    send_item(item_at(CMD_PACKET, 48'd800, 4'd1, 4'd5, 1'b1, 1'b0));
    // frames past the burst end
    send_item(item_at(CMD_PACKET, 48'd900, 4'd9, 4'd5, 1'b1, 1'b0));
    send_item(item_at(CMD_PACKET, 48'd950, 4'd6, 4'd5, 1'b1, 1'b0));
    send_item(item_at(CMD_PACKET, 48'd1000, 4'd5, 4'd5, 1'b1, 1'b0));
    send_item(item_at(CMD_TIMEOUT, 48'd1100, 4'd0, 4'd0, 1'b0, 1'b0));
    send_item(item_at(CMD_START, 48'd1200, 4'd0, 4'd0, 1'b0, 1'b0));
    send_item(item_at(CMD_TIMEOUT, 48'd1300, 4'd0, 4'd0, 1'b0, 1'b0));
    send_item(item_at(CMD_PACKET, NOW_MAX, 4'hF, 4'hF, 1'b0, 1'b1));
    send_item(item_at(CMD_PACKET, NOW_MAX - 48'd1, 4'hE, 4'hF, 1'b0, 1'b0));
    send_item(item_at(CMD_PACKET, NOW_MAX, 4'hF, 4'hE, 1'b0, 1'b0));
    wait_idle();
    cfg_write(REG_AIRTIME, 32'(AIRTIME_MAX));
    send_item(item_at(CMD_PACKET, NOW_MAX - 48'd3, 4'd0, 4'hF, 1'b1, 1'b0));
    wait_idle();
  endtask

  task automatic test_random_windows();
    logic [19:0] airtimes[4];
    logic [3:0]  groups[4];
    int          target;
    airtimes = '{AIRTIME_MAX, 20'd0, 20'($urandom), 20'($urandom_range(255))};
    groups   = '{GROUP_MAX, 4'd0, 4'($urandom), GROUP_MAX};
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_AIRTIME, 32'(airtimes[ph]));
      cfg_write(REG_GROUP, 32'(groups[ph]));
      if (ph == 0) wall_us = 48'hFFFF_FFF0_0000;
      sender_calm = (ph == 1);
      sink_calm   = (ph == 1);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(99) < 85) run_window();
        else send_item(noise_item());
      end
      wait_idle();
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  task automatic test_output_backpressure();
    int target;
    sender_calm = 1'b1;
    sink_hold   = 300;
    target = items_sent + 40;
    while (items_sent < target) run_window();
    sender_calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_sender_pause();
    for (int n = 0; n < 3; n++) begin
      run_window();
      wait_idle();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_commands();
    test_burst_rules();
    test_random_windows();
    test_output_backpressure();
    test_sender_pause();
    wait_idle();
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/brat_pkg.sv
src/brat_cfg_regs.sv
src/brat_core.sv
src/burst_receive_ack_tracker_top.sv
src/brat_checker.sv
tb/sv/burst_receive_ack_tracker_top_tb.sv
